// ----- hw/rtl/psc_pkg.sv -----
// Shared types and constants for the pursuit steering controller.
// No dependencies; every other file uses it by scoped names.
package psc_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned DiffW    = 17;
  localparam int unsigned CordW    = 28;
  localparam int unsigned AngW     = 21;
  localparam int unsigned DistW    = 18;
  localparam int unsigned ErrW     = 18;
  localparam int unsigned StepIdxW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic signed [AngW-1:0] PiQ16        = 21'sd205887;
  localparam logic signed [19:0]     PiQ13        = 20'sd25736;
  localparam logic signed [19:0]     TwoPiQ13     = 20'sd51472;
  localparam logic [ErrW-1:0]        QuarterPiQ13 = 18'd6434;
  localparam logic [15:0]            InvKQ16      = 16'd39797;
  localparam logic [14:0]            Point3Q16    = 15'd19661;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLinGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngGain  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDistDz   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAngDz    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLinLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAngLimit = 3'd5;

  localparam logic FuncFollower = 1'b0;
  localparam logic FuncLeader   = 1'b1;

  typedef struct packed {
    logic                   func;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] heading;
  } in_t;

  typedef struct packed {
    logic [14:0]        linear_speed;
    logic signed [15:0] angular_speed;
  } out_t;

  // leader job handed from front to back
  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [PosW-1:0]  hdg;
  } job_t;

  typedef struct packed {
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
    logic [14:0] distance_deadzone;
    logic [14:0] err_deadzone;
    logic [14:0] linear_limit;
    logic [14:0] angular_limit;
  } cfg_t;

  // arctan(2^-i) in radians * 2^16
  function automatic logic [AngW-1:0] atan_lut(input logic [StepIdxW-1:0] idx);
    logic [AngW-1:0] r;
    unique case (idx)
      5'd0:    r = 21'd51472;
      5'd1:    r = 21'd30386;
      5'd2:    r = 21'd16055;
      5'd3:    r = 21'd8150;
      5'd4:    r = 21'd4091;
      5'd5:    r = 21'd2047;
      5'd6:    r = 21'd1024;
      5'd7:    r = 21'd512;
      5'd8:    r = 21'd256;
      5'd9:    r = 21'd128;
      5'd10:   r = 21'd64;
      5'd11:   r = 21'd32;
      5'd12:   r = 21'd16;
      5'd13:   r = 21'd8;
      5'd14:   r = 21'd4;
      5'd15:   r = 21'd2;
      5'd16:   r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/psc_queue.sv -----
// Two-entry job queue between front and back.
// Depends on psc_pkg for the job type.
module psc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psc_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output psc_pkg::job_t pop_data_o
);

  psc_pkg::job_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/psc_front.sv -----
// Front end: accepts pose beats, latches follower pose, issues leader jobs.
// Depends on psc_pkg.
module psc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psc_pkg::in_t  in_data_i,
  output logic          full_o,
  output logic          job_push_o,
  output psc_pkg::job_t job_o,
  input  logic          job_full_i
);

  logic signed [15:0] fol_x_q, fol_y_q, fol_hdg_q;
  logic               accept;

  // full follows the job queue for both kinds of beat
  assign full_o     = job_full_i;
  assign accept     = push_i && !job_full_i;
  assign job_push_o = accept && (in_data_i.func == psc_pkg::FuncLeader);

  assign job_o.dx  = 17'(in_data_i.pos_x) - 17'(fol_x_q);
  assign job_o.dy  = 17'(in_data_i.pos_y) - 17'(fol_y_q);
  assign job_o.hdg = fol_hdg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fol_x_q   <= '0;
      fol_y_q   <= '0;
      fol_hdg_q <= '0;
    end else if (accept && in_data_i.func == psc_pkg::FuncFollower) begin
      fol_x_q   <= in_data_i.pos_x;
      fol_y_q   <= in_data_i.pos_y;
      fol_hdg_q <= in_data_i.heading;
    end
  end

endmodule

// ----- hw/rtl/psc_back.sv -----
// Back end: iterative vectoring CORDIC, gain/clamp arithmetic, result register.
// Depends on psc_pkg.
module psc_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psc_pkg::cfg_t cfg_i,
  input  logic          job_valid_i,
  input  psc_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output psc_pkg::out_t out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_MAG  = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  localparam logic [psc_pkg::StepIdxW-1:0] LastStep =
    psc_pkg::StepIdxW'(CORDIC_STEPS - 1);

  state_e state_q, state_d;
  logic [psc_pkg::StepIdxW-1:0] cnt_q;
  logic signed [psc_pkg::CordW-1:0] x_q, y_q;
  logic signed [psc_pkg::AngW-1:0]  z_q;
  logic                             zero_q;
  logic signed [psc_pkg::PosW-1:0]  hdg_q;
  logic [psc_pkg::DistW-1:0]        dist_q;
  logic signed [psc_pkg::ErrW-1:0]  err_q;
  logic [22:0]                      lin_p_q;
  logic signed [21:0]               ang_p_q;
  logic                             dz_q, adz_q, big_q;
  logic                             res_valid_q;
  psc_pkg::out_t                    res_q;

  // load / pre-rotation
  logic signed [psc_pkg::CordW-1:0] x0, y0;
  logic signed [psc_pkg::AngW-1:0]  z0;
  // rotation step
  logic signed [psc_pkg::CordW-1:0] xs, ys, x_n, y_n;
  logic signed [psc_pkg::AngW-1:0]  a_i, z_n;
  // magnitude and heading error
  logic [43:0]                      mag_p;
  logic signed [psc_pkg::AngW-1:0]  z_r;
  logic signed [19:0]               err_raw, err_w;
  logic [psc_pkg::DistW-1:0]        dist_w;
  logic signed [psc_pkg::ErrW-1:0]  err_m;
  logic [psc_pkg::ErrW-1:0]         aerr;
  // products
  logic [34:0]                      lin_prod;
  logic signed [35:0]               ang_prod;
  // final
  logic [14:0]                      lin_c;
  logic signed [21:0]               ang_c, lim_pos, lim_neg;
  logic [30:0]                      scale_p;
  logic [14:0]                      lin_f;
  logic                             fin_go;

  always_comb begin
    x0 = psc_pkg::CordW'(job_i.dx) <<< 8;
    y0 = psc_pkg::CordW'(job_i.dy) <<< 8;
    z0 = '0;
    if (job_i.dx < 0) begin
      z0 = (job_i.dy >= 0) ? psc_pkg::PiQ16 : -psc_pkg::PiQ16;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_comb begin
    xs  = x_q >>> cnt_q;
    ys  = y_q >>> cnt_q;
    a_i = psc_pkg::atan_lut(cnt_q);
    if (y_q > 0) begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + a_i;
    end else begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - a_i;
    end
  end

  always_comb begin
    mag_p   = 44'(unsigned'(x_q)) * 44'(psc_pkg::InvKQ16) + 44'(24'h800000);
    z_r     = (z_q + psc_pkg::AngW'(4)) >>> 3;
    err_raw = zero_q ? -20'(hdg_q) : 20'(z_r) - 20'(hdg_q);
    if (err_raw > psc_pkg::PiQ13) begin
      err_w = err_raw - psc_pkg::TwoPiQ13;
    end else if (err_raw <= -psc_pkg::PiQ13) begin
      err_w = err_raw + psc_pkg::TwoPiQ13;
    end else begin
      err_w = err_raw;
    end
    err_m  = psc_pkg::ErrW'(err_w);
    dist_w = zero_q ? '0 : mag_p[24 +: psc_pkg::DistW];
  end

  always_comb begin
    lin_prod = 35'(dist_q) * 35'(cfg_i.linear_gain) + 35'(2048);
    ang_prod = 36'(err_q) * signed'({20'd0, cfg_i.angular_gain}) + 36'sd4096;
    aerr     = err_q[psc_pkg::ErrW-1] ? psc_pkg::ErrW'(-err_q) : psc_pkg::ErrW'(err_q);
  end

  always_comb begin
    lin_c   = (lin_p_q > 23'(cfg_i.linear_limit)) ? cfg_i.linear_limit : lin_p_q[14:0];
    lim_pos = 22'(cfg_i.angular_limit);
    lim_neg = -lim_pos;
    if (adz_q) begin
      ang_c = '0;
    end else if (ang_p_q > lim_pos) begin
      ang_c = lim_pos;
    end else if (ang_p_q < lim_neg) begin
      ang_c = lim_neg;
    end else begin
      ang_c = ang_p_q;
    end
    scale_p = 31'(lin_c) * 31'(psc_pkg::Point3Q16) + 31'(32768);
    lin_f   = big_q ? scale_p[16 +: 15] : lin_c;
    fin_go  = (state_q == S_FIN) && !res_valid_q;
  end

  assign job_pop_o  = (state_q == S_IDLE) && job_valid_i;
  assign empty_o    = !res_valid_q;
  assign out_data_o = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (job_valid_i) state_d = S_ROT;
      S_ROT:  if (cnt_q == LastStep) state_d = S_MAG;
      S_MAG:  state_d = S_MUL;
      S_MUL:  state_d = S_FIN;
      S_FIN:  if (!res_valid_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == S_ROT) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (fin_go) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        x_q    <= x0;
        y_q    <= y0;
        z_q    <= z0;
        zero_q <= (job_i.dx == 0) && (job_i.dy == 0);
        hdg_q  <= job_i.hdg;
      end
      S_ROT: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
      S_MAG: begin
        dist_q <= dist_w;
        err_q  <= err_m;
      end
      S_MUL: begin
        lin_p_q <= lin_prod[12 +: 23];
        ang_p_q <= ang_prod[13 +: 22];
        dz_q    <= dist_q < psc_pkg::DistW'(cfg_i.distance_deadzone);
        adz_q   <= aerr < psc_pkg::ErrW'(cfg_i.err_deadzone);
        big_q   <= aerr > psc_pkg::QuarterPiQ13;
      end
      S_FIN: begin
        if (fin_go) begin
          res_q.linear_speed  <= dz_q ? '0 : lin_f;
          res_q.angular_speed <= dz_q ? '0 : 16'(ang_c);
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/pursuit_steering_controller_top.sv -----
// Pursuit steering controller: pose beats in, velocity command beats out.
// Uses psc_pkg, psc_front, psc_queue and psc_back.
//
// Input: push/full queue write. func 0 latches the follower pose and
// yields nothing; func 1 (leader) yields one command on the output queue.
// Output: empty/pop queue read; out_data_o holds the oldest result while
// empty is low.
// Config: cfg_valid/cfg_ready, always ready; write only when idle.
// Unknown indexes are dropped.
// Flow: a leader beat is written into the job queue, loaded by the back end
// in IDLE, rotated for CORDIC_STEPS iterations in ROT, then passed through MAG,
// MUL and FIN into the result register. The back end takes one leader beat at a
// time on the single shared CORDIC rotator; follower beats stay in the front end.
// Two jobs can queue up in front of the back end; when the result is not
// popped the back end holds in its final stage and the queue fills, then
// full rises.
// Reset: registers return to their defaults, follower pose goes to zero,
// both queues empty.
module pursuit_steering_controller_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  psc_pkg::in_t                     in_data_i,
  output logic                             empty,
  input  logic                             pop,
  output psc_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [psc_pkg::CfgDataW-1:0]     cfg_data_i
);

  psc_pkg::cfg_t cfg_q;
  psc_pkg::job_t job_in, job_out;
  logic          job_push, job_full, job_valid, job_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain       <= 16'd3277;
      cfg_q.angular_gain      <= 16'd16384;
      cfg_q.distance_deadzone <= 15'd102;
      cfg_q.err_deadzone      <= 15'd164;
      cfg_q.linear_limit      <= 15'd4096;
      cfg_q.angular_limit     <= 15'd20480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        psc_pkg::RegLinGain:  cfg_q.linear_gain       <= cfg_data_i;
        psc_pkg::RegAngGain:  cfg_q.angular_gain      <= cfg_data_i;
        psc_pkg::RegDistDz:   cfg_q.distance_deadzone <= cfg_data_i[14:0];
        psc_pkg::RegAngDz:    cfg_q.err_deadzone      <= cfg_data_i[14:0];
        psc_pkg::RegLinLimit: cfg_q.linear_limit      <= cfg_data_i[14:0];
        psc_pkg::RegAngLimit: cfg_q.angular_limit     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  psc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  psc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .pop_data_o  (job_out)
  );

  psc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data_o)
  );

  // a waiting command never exceeds its clamps
  a_lin_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_data_o.linear_speed <= cfg_q.linear_limit)
    else $error("linear speed above limit");

  a_ang_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ($signed(17'(out_data_o.angular_speed)) <= $signed({2'b00, cfg_q.angular_limit})
             && $signed(17'(out_data_o.angular_speed)) >= -$signed({2'b00, cfg_q.angular_limit})))
    else $error("angular speed outside limit");

  // a job only leaves the queue when one is there
  a_job_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

endmodule
